// ===== sv/phcc_pkg.sv =====
// ----------------------------------------------------------------------------
// phcc_pkg: shared types and constants for the packet header CRC checker
// Holds the transfer structs, header byte positions and the CRC byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package phcc_pkg;

    localparam int unsigned HDR_BYTES = 7;
    localparam int unsigned POS_W     = 3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // header byte positions
    localparam logic [POS_W-1:0] POS_SEQ_HI = 3'd0;
    localparam logic [POS_W-1:0] POS_SEQ_LO = 3'd1;
    localparam logic [POS_W-1:0] POS_FLAGS  = 3'd2;
    localparam logic [POS_W-1:0] POS_CRC_HI = 3'd3;
    localparam logic [POS_W-1:0] POS_CRC_LO = 3'd4;
    localparam logic [POS_W-1:0] POS_LEN_HI = 3'd5;
    localparam logic [POS_W-1:0] POS_LEN_LO = 3'd6;
    localparam logic [POS_W-1:0] POS_BODY   = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] seq_num;
        logic [7:0]  flag_bits;
        logic [15:0] stored_checksum;
        logic [15:0] body_length;
        logic        checksum_ok;
        logic        too_short;
    } t_out_item;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/phcc_core.sv =====
// ----------------------------------------------------------------------------
// phcc_core: header capture and running CRC
// Tracks the byte position, captures header fields, and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module phcc_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire phcc_pkg::t_in_item i_item,
    output phcc_pkg::t_out_item    o_result
);
    import phcc_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_crc, n_crc;
    logic [15:0]      r_seq, n_seq;
    logic [7:0]       r_flags, n_flags;
    logic [15:0]      r_chk, n_chk;
    logic [15:0]      r_len, n_len;
    logic [7:0]       fed;
    logic             short_pkt;

    always_comb begin
        n_seq   = r_seq;
        n_flags = r_flags;
        n_chk   = r_chk;
        n_len   = r_len;
        fed     = i_item.data_byte;
        case (r_pos)
            POS_SEQ_HI: n_seq   = {i_item.data_byte, 8'h00};
            POS_SEQ_LO: n_seq   = {r_seq[15:8], i_item.data_byte};
            POS_FLAGS:  n_flags = i_item.data_byte;
            POS_CRC_HI: begin
                n_chk = {i_item.data_byte, 8'h00};
                fed   = 8'h00;
            end
            POS_CRC_LO: begin
                n_chk = {r_chk[15:8], i_item.data_byte};
                fed   = 8'h00;
            end
            POS_LEN_HI: n_len   = {i_item.data_byte, 8'h00};
            POS_LEN_LO: n_len   = {r_len[15:8], i_item.data_byte};
            default: ;
        endcase
        n_crc = crc_feed(r_crc, fed);
        n_pos = (r_pos == POS_BODY) ? r_pos : r_pos + 1'b1;
    end

    assign short_pkt = (n_pos != POS_BODY);

    always_comb begin
        o_result.seq_num         = short_pkt ? 16'h0000 : n_seq;
        o_result.flag_bits       = short_pkt ? 8'h00    : n_flags;
        o_result.stored_checksum = short_pkt ? 16'h0000 : n_chk;
        o_result.body_length     = short_pkt ? 16'h0000 : n_len;
        o_result.checksum_ok     = !short_pkt && (n_crc == n_chk);
        o_result.too_short       = short_pkt;
    end

    // control state: return to idle after the marked byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_SEQ_HI;
            r_crc <= CRC_INIT;
        end else if (i_step) begin
            if (i_item.last_byte) begin
                r_pos <= POS_SEQ_HI;
                r_crc <= CRC_INIT;
            end else begin
                r_pos <= n_pos;
                r_crc <= n_crc;
            end
        end
    end

    // header captures are rewritten before use in every complete header
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_seq   <= n_seq;
            r_flags <= n_flags;
            r_chk   <= n_chk;
            r_len   <= n_len;
        end
    end

endmodule

`default_nettype wire

// ===== sv/packet_header_crc_check_top.sv =====
// ----------------------------------------------------------------------------
// packet_header_crc_check_top: receive-side packet header and CRC checker
// Takes packet bytes one per transfer, reports header and CRC status per packet.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one byte per
//   transfer plus a mark on the final byte of a packet. The first seven bytes
//   form a big-endian header: sequence, flags, stored CRC, payload length.
//   A CRC-16/CCITT-FALSE runs over all bytes with the stored CRC bytes as zero.
//   Output channel (o_out_valid / i_out_stall / o_out_data) carries one
//   transfer per packet, produced from the marked byte. Packets shorter than
//   the header report too_short with zeroed header fields and no match.
//   The marked byte's result passes the input register, then the result
//   register. Bytes are taken one per cycle unless a final byte waits on a
//   receiver stall, using the byte-parallel CRC update in the core.
//   Reset (synchronous, active low) empties both registers and restarts the
//   byte position and CRC. When the receiver stalls, the result register
//   holds; non-final bytes keep flowing, and a final byte waits in the input
//   register, which then stalls the sender.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_header_crc_check_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire phcc_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output phcc_pkg::t_out_item    o_out_data
);
    import phcc_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item result;
    logic      out_open;
    logic      step;
    logic      in_load;

    // result register can take a new transfer
    assign out_open = !r_out_valid || !i_out_stall;
    // advance the held byte: non-final bytes never need the result register
    assign step     = r_in_valid && (!r_in_data.last_byte || out_open);
    assign in_load  = !r_in_valid || step;

    assign o_in_stall  = !in_load;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    phcc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_data),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    // result register: load on the final byte, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_open) begin
            r_out_valid <= step && r_in_data.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_open && step && r_in_data.last_byte) begin
            r_out_data <= result;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_packet_header_crc_check_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packet_header_crc_check_top: self-checking bench for the packet checker
// Streams packets one byte per transfer and predicts each header report with
// a bitwise CRC-16 model. Directed packets, some with pinned results, come first,
// then random packets with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_packet_header_crc_check_top;

    import phcc_pkg::*;

    localparam int unsigned BYTE_BUDGET = 2000;

    // One directed packet: header fields, body fill byte, and an optional
    // result that is typed in rather than taken from the predictor.
    typedef struct {
        int          len;
        logic [15:0] seq;
        logic [7:0]  flags;
        logic [15:0] cks;
        logic [15:0] plen;
        logic [7:0]  fill;
        bit          fix_crc;
        bit          pinned;
        t_out_item   hdr;
    } t_pkt_row;

    typedef struct {
        bit        pinned;
        t_out_item hdr;
    } t_pinned_hdr;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;

    // Expected reports, oldest first, and the pinned results per packet
    t_out_item   headers_due [$];
    t_pinned_hdr pinned_per_pkt [$];

    // Predictor state: mirrors the checker's header capture and running CRC
    logic [2:0]  hdr_pos;
    logic [15:0] run_crc;
    logic [15:0] seq_acc;
    logic [7:0]  flags_acc;
    logic [15:0] cks_acc;
    logic [15:0] len_acc;

    int        mismatches;
    int        bytes_sent;
    int        rx_run_left;
    bit        steady;
    t_out_item got_hdr;
    t_out_item want_hdr;
    t_pkt_row  directed_rows [4];

    packet_header_crc_check_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Bitwise CRC-16/CCITT-FALSE step: shift one message bit at a time
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Mostly no gap, sometimes a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic clear_tracker();
        hdr_pos   = '0;
        run_crc   = CRC_INIT;
        seq_acc   = '0;
        flags_acc = '0;
        cks_acc   = '0;
        len_acc   = '0;
    endtask

    // Advance the predictor by one accepted byte; queue a report on the last one
    task automatic track_byte(input t_in_item it);
        logic [7:0]  fed;
        logic        short_pkt;
        t_out_item   rpt;
        t_pinned_hdr pin;
        fed = it.data_byte;
        case (hdr_pos)
            POS_SEQ_HI: begin
                seq_acc = {it.data_byte, 8'h00};
            end
            POS_SEQ_LO: begin
                seq_acc[7:0] = it.data_byte;
            end
            POS_FLAGS: begin
                flags_acc = it.data_byte;
            end
            POS_CRC_HI: begin
                cks_acc = {it.data_byte, 8'h00};
                fed     = 8'h00;
            end
            POS_CRC_LO: begin
                cks_acc[7:0] = it.data_byte;
                fed          = 8'h00;
            end
            POS_LEN_HI: begin
                len_acc = {it.data_byte, 8'h00};
            end
            POS_LEN_LO: begin
                len_acc[7:0] = it.data_byte;
            end
            default: begin
            end
        endcase
        run_crc = crc16_step(run_crc, fed);
        // hold the position at the body mark once the header is in
        if (hdr_pos != POS_BODY) begin
            hdr_pos = hdr_pos + 3'd1;
        end
        if (it.last_byte) begin
            short_pkt           = (hdr_pos != POS_BODY);
            rpt.seq_num         = short_pkt ? 16'h0000 : seq_acc;
            rpt.flag_bits       = short_pkt ? 8'h00 : flags_acc;
            rpt.stored_checksum = short_pkt ? 16'h0000 : cks_acc;
            rpt.body_length     = short_pkt ? 16'h0000 : len_acc;
            rpt.checksum_ok     = !short_pkt && (run_crc == cks_acc);
            rpt.too_short       = short_pkt;
            pin = pinned_per_pkt.pop_front();
            // a pinned result replaces the predicted one for that packet
            headers_due.push_back(pin.pinned ? pin.hdr : rpt);
            clear_tracker();
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: sample both channels at the rising edge. Check the result
    // first; it always belongs to an earlier byte than this edge's input.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got_hdr = out_data;
                if (headers_due.size() == 0) begin
                    $error("result transfer with nothing expected: 0x%0h", got_hdr);
                    mismatches++;
                end else begin
                    want_hdr = headers_due.pop_front();
                    check_field("seq_num", want_hdr.seq_num, got_hdr.seq_num);
                    check_field("flag_bits", 16'(want_hdr.flag_bits),
                                16'(got_hdr.flag_bits));
                    check_field("stored_checksum", want_hdr.stored_checksum,
                                got_hdr.stored_checksum);
                    check_field("body_length", want_hdr.body_length,
                                got_hdr.body_length);
                    check_field("checksum_ok", 16'(want_hdr.checksum_ok),
                                16'(got_hdr.checksum_ok));
                    check_field("too_short", 16'(want_hdr.too_short),
                                16'(got_hdr.too_short));
                end
            end
            if (in_valid && !in_stall) begin
                track_byte(in_data);
            end
        end
    end

    // Receiver: stall in random stretches; no stall stretch starts in a steady phase
    always @(negedge clk) begin
        if (rx_run_left != 0) begin
            rx_run_left <= rx_run_left - 1;
        end else begin
            out_stall   <= !steady && ($urandom_range(0, 99) < 35);
            rx_run_left <= pick_gap();
        end
    end

    // Drive one byte: idle for a gap, then hold the transfer until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        int       gap;
        t_in_item it;
        gap          = steady ? 0 : pick_gap();
        it.data_byte = b;
        it.last_byte = last;
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        do begin
            @(posedge clk);
        end while (in_stall);
        bytes_sent++;
    endtask

    // Assemble a packet from header fields and a body, optionally patch the
    // stored checksum so that it matches, then stream it out
    task automatic emit_frame(input int len, input logic [15:0] seq, input logic [7:0] flags,
                              input logic [15:0] cks, input logic [15:0] plen,
                              input bit rand_body, input logic [7:0] fill,
                              input bit fix_crc, input t_pinned_hdr pin);
        logic [7:0]  pkt [$];
        logic [7:0]  hdr [7];
        logic [15:0] crc;
        hdr = '{seq[15:8], seq[7:0], flags, cks[15:8], cks[7:0], plen[15:8], plen[7:0]};
        for (int i = 0; i < len; i++) begin
            if (i < HDR_BYTES) begin
                pkt.push_back(hdr[i]);
            end else begin
                pkt.push_back(rand_body ? 8'($urandom) : fill);
            end
        end
        if (fix_crc && len >= HDR_BYTES) begin
            crc = CRC_INIT;
            for (int i = 0; i < len; i++) begin
                crc = crc16_step(crc, (i == POS_CRC_HI || i == POS_CRC_LO) ? 8'h00 : pkt[i]);
            end
            pkt[POS_CRC_HI] = crc[15:8];
            pkt[POS_CRC_LO] = crc[7:0];
        end
        pinned_per_pkt.push_back(pin);
        for (int i = 0; i < len; i++) begin
            send_byte(pkt[i], i == len - 1);
        end
    endtask

    initial begin
        t_pinned_hdr pin;
        t_pkt_row    row;
        int          r;
        int          len;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        rx_run_left = 0;
        steady      = 1'b0;
        mismatches  = 0;
        bytes_sent  = 0;
        clear_tracker();

        // Directed packets: a lone byte, the longest short packet with every
        // header bit set, a full header of all ones, and a matching packet
        // one byte past the header so the position saturates
        directed_rows[0] = '{1, 16'h0000, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1,
                             '{16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b1}};
        directed_rows[1] = '{6, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b1,
                             '{16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b1}};
        directed_rows[2] = '{7, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0,
                             '{16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0}};
        directed_rows[3] = '{8, 16'h0000, 8'h00, 16'h0000, 16'h0000, 8'h5A, 1'b1, 1'b0,
                             '{16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0}};

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            row        = directed_rows[k];
            pin.pinned = row.pinned;
            pin.hdr    = row.hdr;
            emit_frame(row.len, row.seq, row.flags, row.cks, row.plen, 1'b0, row.fill,
                       row.fix_crc, pin);
        end

        // Random packets: mostly full headers with a matching checksum, plus
        // short packets, corrupted checksums and the odd long body
        pin.pinned = 1'b0;
        pin.hdr    = '0;
        while (bytes_sent < BYTE_BUDGET) begin
            if ($urandom_range(0, 99) < 20) begin
                steady = !steady;
            end
            r = $urandom_range(0, 99);
            if (r < 12) begin
                len = $urandom_range(1, 6);
            end else if (r < 85) begin
                len = $urandom_range(7, 16);
            end else begin
                len = $urandom_range(17, 48);
            end
            emit_frame(len, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 1'b1,
                       8'h00, $urandom_range(0, 3) != 0, pin);
        end
        steady = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain: wait for every report, then watch for strays
        while (headers_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: many times the slowest correct run
    initial begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
